@@ rtl/pccp_pkg.sv @@
// Shared types and constants for the printer control code parser.
// No dependencies; imported by every module of the block.
package pccp_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Command held by the front-end argument buffer
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_TAB    = 2'd1,
    CMD_REPEAT = 2'd2,
    CMD_DOT    = 2'd3
  } cmd_t;

  // Classified work handed from the front end to the back end
  typedef enum logic [2:0] {
    ACT_CHAR   = 3'd0,
    ACT_BITMAP = 3'd1,
    ACT_REPEAT = 3'd2,
    ACT_TAB    = 3'd3,
    ACT_DOT    = 3'd4,
    ACT_LF     = 3'd5
  } act_kind_t;

  typedef struct packed {
    act_kind_t   kind;
    logic [7:0]  code;
    logic [2:0]  font;
    logic [15:0] arg;   // repeat count, dot column, or tab column (two's complement, 8 bits)
    logic        wide;  // enhanced character: double advance
    logic        fine;  // eight point line pitch
  } act_t;

  // Event kinds on the output
  localparam logic [2:0] EV_CHAR   = 3'd0;
  localparam logic [2:0] EV_BITMAP = 3'd1;
  localparam logic [2:0] EV_REPEAT = 3'd2;
  localparam logic [2:0] EV_PAD    = 3'd3;
  localparam logic [2:0] EV_LF     = 3'd4;

  // Fonts
  localparam logic [2:0] FONT_GRAPHIC   = 3'd1;
  localparam logic [2:0] FONT_BUSINESS  = 3'd3;
  localparam logic [2:0] FONT_BIT_IMAGE = 3'd5;

  // Line pitch in points
  localparam logic [3:0] PITCH_FINE   = 4'd8;
  localparam logic [3:0] PITCH_NORMAL = 4'd12;

  // Control bytes
  localparam logic [7:0] BYTE_BIT_IMAGE = 8'd8;
  localparam logic [7:0] BYTE_LF        = 8'd10;
  localparam logic [7:0] BYTE_ENH_ON    = 8'd14;
  localparam logic [7:0] BYTE_ENH_OFF   = 8'd15;
  localparam logic [7:0] BYTE_TAB       = 8'd16;
  localparam logic [7:0] BYTE_LOCK_BUS  = 8'd17;
  localparam logic [7:0] BYTE_REPEAT    = 8'd26;
  localparam logic [7:0] BYTE_DOT       = 8'd27;
  localparam logic [7:0] BYTE_LOCK_GR   = 8'd145;
  localparam logic [7:0] CHANNEL_BUS    = 8'd7;
  localparam logic [7:0] CODE_SPACE     = 8'h20;

endpackage

@@ rtl/pccp_front.sv @@
// Front end: accepts bytes, tracks modes and command arguments, classifies work.
// Depends on pccp_pkg.
module pccp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            op,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      channel,
  output logic            act_push,
  output pccp_pkg::act_t  act
);
  import pccp_pkg::*;

  logic       enhanced, enhanced_next;
  logic       bit_image, bit_image_next;
  logic       set_lock, set_lock_next;
  logic       business, business_next;
  logic       pitch_fine, pitch_fine_next;
  logic       cmd_active, cmd_active_next;
  cmd_t       cmd_code, cmd_code_next;
  logic [1:0] arg_count, arg_count_next;
  logic [7:0] arg0, arg0_next;
  logic [7:0] arg1, arg1_next;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Decimal column of a tab: two bytes, third byte always zero
  function automatic logic [7:0] parse_tab(input logic [7:0] b0, input logic [7:0] b1);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] v;
    d0 = {4'd0, b0[3:0]};
    d1 = {4'd0, b1[3:0]};
    v  = '0;
    if (is_ws(b0)) begin
      if (is_digit(b1)) v = d1;
    end else if (b0 == 8'h2b) begin
      if (is_digit(b1)) v = d1;
    end else if (b0 == 8'h2d) begin
      if (is_digit(b1)) v = 8'(8'd0 - d1);
    end else if (is_digit(b0)) begin
      if (is_digit(b1)) v = 8'(d0 * 8'd10 + d1);
      else v = d0;
    end
    return v;
  endfunction

  function automatic logic [2:0] mode_font(input logic bs, input logic enh);
    return (bs ? FONT_BUSINESS : FONT_GRAPHIC) + {2'b00, enh};
  endfunction

  always_comb begin
    logic bs;
    enhanced_next   = enhanced;
    bit_image_next  = bit_image;
    set_lock_next   = set_lock;
    business_next   = business;
    pitch_fine_next = pitch_fine;
    cmd_active_next = cmd_active;
    cmd_code_next   = cmd_code;
    arg_count_next  = arg_count;
    arg0_next       = arg0;
    arg1_next       = arg1;
    bs              = set_lock ? business : (channel == CHANNEL_BUS);
    act_push        = 1'b0;
    act.kind        = ACT_CHAR;
    act.code        = data_byte;
    act.font        = FONT_BIT_IMAGE;
    act.arg         = 16'd1;
    act.wide        = enhanced;
    act.fine        = pitch_fine;

    if (accept) begin
      if (op) begin
        enhanced_next  = 1'b0;
        bit_image_next = 1'b0;
        set_lock_next  = 1'b0;
      end else begin
        business_next = bs;
        if (bit_image) begin
          if (data_byte == BYTE_ENH_ON || data_byte == BYTE_ENH_OFF) begin
            enhanced_next   = (data_byte == BYTE_ENH_ON);
            bit_image_next  = 1'b0;
            pitch_fine_next = 1'b0;
          end else if (data_byte == BYTE_REPEAT) begin
            bit_image_next  = 1'b0;
            cmd_active_next = 1'b1;
            cmd_code_next   = CMD_REPEAT;
          end else begin
            act_push = 1'b1;
            act.kind = ACT_BITMAP;
          end
        end else if (cmd_active) begin
          // default: drop the command
          cmd_active_next = 1'b0;
          cmd_code_next   = CMD_NONE;
          arg_count_next  = 2'd0;
          case (arg_count)
            2'd0: begin
              arg0_next       = data_byte;
              arg_count_next  = 2'd1;
              cmd_active_next = 1'b1;
              cmd_code_next   = cmd_code;
            end
            2'd1: begin
              arg1_next = data_byte;
              case (cmd_code)
                CMD_TAB: begin
                  act_push = 1'b1;
                  act.kind = ACT_TAB;
                  act.font = FONT_GRAPHIC;
                  act.arg  = {{8{1'b0}}, parse_tab(arg0, data_byte)};
                end
                CMD_REPEAT: begin
                  act_push = 1'b1;
                  act.kind = ACT_REPEAT;
                  act.arg  = (arg0 == 8'd0) ? 16'd256 : {8'd0, arg0};
                end
                CMD_DOT: begin
                  arg_count_next  = 2'd2;
                  cmd_active_next = 1'b1;
                  cmd_code_next   = cmd_code;
                end
                default: ;
              endcase
            end
            2'd2: begin
              if (cmd_code == CMD_DOT) begin
                act_push = 1'b1;
                act.kind = ACT_DOT;
                act.arg  = {arg1, data_byte};
              end
            end
            default: ;
          endcase
        end else begin
          case (data_byte)
            BYTE_ENH_ON:  enhanced_next = 1'b1;
            BYTE_ENH_OFF: enhanced_next = 1'b0;
            BYTE_BIT_IMAGE: begin
              bit_image_next  = 1'b1;
              pitch_fine_next = 1'b1;
            end
            BYTE_LF: begin
              act_push = 1'b1;
              act.kind = ACT_LF;
              act.code = 8'd0;
              act.font = mode_font(bs, enhanced);
            end
            BYTE_LOCK_BUS: begin
              set_lock_next = 1'b1;
              business_next = 1'b1;
            end
            BYTE_LOCK_GR: begin
              set_lock_next = 1'b1;
              business_next = 1'b0;
            end
            BYTE_TAB: begin
              cmd_active_next = 1'b1;
              cmd_code_next   = CMD_TAB;
            end
            BYTE_DOT: begin
              cmd_active_next = 1'b1;
              cmd_code_next   = CMD_DOT;
            end
            default: begin
              if ((data_byte >= 8'h20 && data_byte <= 8'h7f) || data_byte >= 8'ha0) begin
                act_push = 1'b1;
                act.kind = ACT_CHAR;
                act.font = mode_font(bs, enhanced);
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enhanced   <= 1'b0;
      bit_image  <= 1'b0;
      set_lock   <= 1'b0;
      business   <= 1'b0;
      pitch_fine <= 1'b0;
      cmd_active <= 1'b0;
      cmd_code   <= CMD_NONE;
      arg_count  <= 2'd0;
    end else begin
      enhanced   <= enhanced_next;
      bit_image  <= bit_image_next;
      set_lock   <= set_lock_next;
      business   <= business_next;
      pitch_fine <= pitch_fine_next;
      cmd_active <= cmd_active_next;
      cmd_code   <= cmd_code_next;
      arg_count  <= arg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    arg0 <= arg0_next;
    arg1 <= arg1_next;
  end

endmodule

@@ rtl/pccp_queue.sv @@
// Short action queue between the front end and the back end.
// Depends on pccp_pkg for the action type.
module pccp_queue #(
  parameter int DEPTH = pccp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pccp_pkg::act_t  push_data,
  output logic            full,
  input  logic            pop,
  output pccp_pkg::act_t  pop_data,
  output logic            avail
);
  import pccp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  act_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full     = (fill == CNT_W'(DEPTH));
  assign avail    = (fill != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) fill <= CNT_W'(fill + 1'b1);
      else if (pop && !push) fill <= CNT_W'(fill - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/pccp_back.sv @@
// Back end: keeps the print position and its column quotients, emits events.
// Depends on pccp_pkg.
module pccp_back #(
  parameter int POS_BITS = pccp_pkg::POS_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  pccp_pkg::act_t  act,
  output logic            pop,
  output logic            event_valid,
  input  logic            event_stall,
  output logic [2:0]      event_kind,
  output logic [7:0]      code,
  output logic [2:0]      font,
  output logic [15:0]     count,
  output logic [15:0]     x_after,
  output logic [3:0]      line_pitch
);
  import pccp_pkg::*;

  localparam int C72W = POS_BITS - 6;
  localparam int C12W = POS_BITS - 3;
  localparam int WIDE = ((POS_BITS > 16) ? POS_BITS : 16) + 1;
  localparam int POS_MAX_INT = (1 << POS_BITS) - 1;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [C72W-1:0] C72_SAT = C72W'(POS_MAX_INT / 72);
  localparam logic [C12W-1:0] C12_SAT = C12W'(POS_MAX_INT / 12);
  localparam logic [POS_BITS:0] STEP_N = (POS_BITS + 1)'(72);
  localparam logic [POS_BITS:0] STEP_W = (POS_BITS + 1)'(144);

  // x is always a multiple of 72 short of saturation, so the quotients
  // step exactly with it
  logic [POS_BITS-1:0] x, x_next;
  logic [C72W-1:0]     c72, c72_next;
  logic [C12W-1:0]     c12, c12_next;

  logic                emit;
  logic [2:0]          kind_v;
  logic [7:0]          code_v;
  logic [15:0]         count_v;
  logic [POS_BITS:0]   sum;
  logic [WIDE-1:0]     tab_n, dot_n, col72, col12, tab_diff, dot_diff, x_ext;

  assign pop = avail && (!event_valid || !event_stall);

  always_comb begin
    sum      = {1'b0, x} + (act.wide ? STEP_W : STEP_N);
    tab_n    = {{(WIDE - 8){1'b0}}, act.arg[7:0]};
    dot_n    = {{(WIDE - 16){1'b0}}, act.arg};
    col72    = {{(WIDE - C72W){1'b0}}, c72};
    col12    = {{(WIDE - C12W){1'b0}}, c12};
    tab_diff = tab_n - col72;
    dot_diff = dot_n - col12;
    x_next   = x;
    c72_next = c72;
    c12_next = c12;
    emit     = 1'b0;
    kind_v   = EV_CHAR;
    code_v   = act.code;
    count_v  = 16'd1;
    if (pop) begin
      case (act.kind)
        ACT_CHAR: begin
          emit = 1'b1;
          if (sum[POS_BITS]) begin
            x_next   = POS_MAX;
            c72_next = C72_SAT;
            c12_next = C12_SAT;
          end else begin
            x_next   = sum[POS_BITS-1:0];
            c72_next = act.wide ? C72W'(c72 + 2'd2) : C72W'(c72 + 2'd1);
            c12_next = act.wide ? C12W'(c12 + 4'd12) : C12W'(c12 + 4'd6);
          end
        end
        ACT_BITMAP: begin
          emit   = 1'b1;
          kind_v = EV_BITMAP;
        end
        ACT_REPEAT: begin
          emit    = 1'b1;
          kind_v  = EV_REPEAT;
          count_v = act.arg;
        end
        ACT_TAB: begin
          // negative column never pads
          emit    = !act.arg[7] && (tab_n > col72);
          kind_v  = EV_PAD;
          code_v  = CODE_SPACE;
          count_v = tab_diff[15:0];
        end
        ACT_DOT: begin
          emit    = (dot_n > col12);
          kind_v  = EV_PAD;
          code_v  = CODE_SPACE;
          count_v = dot_diff[15:0];
        end
        ACT_LF: begin
          emit     = 1'b1;
          kind_v   = EV_LF;
          x_next   = '0;
          c72_next = '0;
          c12_next = '0;
        end
        default: ;
      endcase
    end
    x_ext = {{(WIDE - POS_BITS){1'b0}}, x_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x           <= '0;
      c72         <= '0;
      c12         <= '0;
      event_valid <= 1'b0;
    end else begin
      x   <= x_next;
      c72 <= c72_next;
      c12 <= c12_next;
      if (pop) event_valid <= emit;
      else if (!event_stall) event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      event_kind <= kind_v;
      code       <= code_v;
      font       <= act.font;
      count      <= count_v;
      x_after    <= x_ext[15:0];
      line_pitch <= act.fine ? PITCH_FINE : PITCH_NORMAL;
    end
  end

endmodule

@@ rtl/printer_control_code_parser_unit.sv @@
// Printer control code parser, top level.
// An accepted byte's action passes the action queue to the registered outputs.
// Throughput: one byte per cycle; the action queue (QUEUE_DEPTH entries) takes up
// output stalls, and item_stall rises only when that queue is full.
// Reset (synchronous, rst high) clears all modes, the command buffer, the print
// position and the queue; the first byte may be sent in the cycle after reset.
module printer_control_code_parser_unit #(
  parameter int POS_BITS    = pccp_pkg::POS_BITS_DEF,
  parameter int QUEUE_DEPTH = pccp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction: one printer byte or a mode clear
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  channel,
  // output transaction: one print event
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  event_kind,
  output logic [7:0]  code,
  output logic [2:0]  font,
  output logic [15:0] count,
  output logic [15:0] x_after,
  output logic [3:0]  line_pitch
);
  import pccp_pkg::*;

  // Front end: owns the mode flags and the tab, dot address and repeat
  // argument buffer. It turns each byte into at most one action, already
  // carrying its font, code and argument, so the back end never looks at modes.
  act_t push_act;
  logic push;
  logic accept;
  logic q_full;

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  pccp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .data_byte (data_byte),
    .channel   (channel),
    .act_push  (push),
    .act       (push_act)
  );

  // Queue decouples the two halves; mode tracking never waits on the position.
  act_t head_act;
  logic head_avail;
  logic pop;

  pccp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_act),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_act),
    .avail     (head_avail)
  );

  // Back end: position in tenths of a point plus running x/72 and x/12, so
  // tab and dot address compares need no divider. Pad actions that land at
  // or behind the current column are consumed without an event.
  pccp_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (head_avail),
    .act         (head_act),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .code        (code),
    .font        (font),
    .count       (count),
    .x_after     (x_after),
    .line_pitch  (line_pitch)
  );

  // A line feed always leaves the head at column zero
  a_lf_home: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == EV_LF) |-> (x_after == 16'd0))
    else $error("line feed with nonzero position");

  // Repeated columns are bit-image and count 1..256
  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == EV_REPEAT) |->
      (font == FONT_BIT_IMAGE && count >= 16'd1 && count <= 16'd256))
    else $error("repeat event out of range");

  // Pad events carry a space and a positive count
  a_pad_count: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == EV_PAD) |-> (code == CODE_SPACE && count != 16'd0))
    else $error("pad event with zero count");

  // Pitch is eight or twelve points
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (line_pitch == PITCH_FINE || line_pitch == PITCH_NORMAL))
    else $error("bad line pitch");

endmodule

@@ test/printer_control_code_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for printer_control_code_parser_unit: directed and random
// byte streams against a behavioral parser model. Depends on pccp_pkg and the RTL.
module printer_control_code_parser_unit_tb;
  import pccp_pkg::*;

  // Operation codes on the op input
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Bytes accepted with no effect
  localparam logic [7:0] BYTE_NOP_A = 8'd18;
  localparam logic [7:0] BYTE_NOP_B = 8'd146;

  // Printable ranges and the line feed code field
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7f;
  localparam logic [7:0] PRINT_UPPER = 8'ha0;
  localparam logic [7:0] CODE_NONE   = 8'h00;

  // Position math, tenths of a point
  localparam int POS_MAX     = (1 << POS_BITS_DEF) - 1;
  localparam int CHAR_W      = 72;
  localparam int CHAR_W_WIDE = 144;
  localparam int DOT_W       = 12;

  localparam int TOTAL_ITEMS = 1900;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [2:0]  font;
    logic [15:0] count;
    logic [15:0] x_after;
    logic [3:0]  pitch;
  } print_event_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        op;
  logic [7:0]  data_byte;
  logic [7:0]  channel;
  logic        event_valid;
  logic        event_stall;
  logic [2:0]  event_kind;
  logic [7:0]  code;
  logic [2:0]  font;
  logic [15:0] count;
  logic [15:0] x_after;
  logic [3:0]  line_pitch;

  printer_control_code_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .op          (op),
    .data_byte   (data_byte),
    .channel     (channel),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .code        (code),
    .font        (font),
    .count       (count),
    .x_after     (x_after),
    .line_pitch  (line_pitch)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model state, updated once per accepted input transaction
  // ---------------------------------------------------------------------------
  logic       m_enhanced;
  logic       m_bit_image;
  logic       m_lock;
  logic       m_business;
  logic       m_cmd_busy;
  logic       m_fine;
  cmd_t       m_cmd;
  int         m_argc;
  logic [7:0] m_args [3];
  int         m_x;

  print_event_t pending_events [$];

  // Run bookkeeping
  int mismatches;
  int items_sent;
  int events_checked;
  int kind_seen [5];
  bit no_gaps;        // when set, neither side adds random idle gaps (a long hold-off still applies)
  int rx_wait;        // receiver stall cycles drawn per transaction
  int hold_request;   // long receiver hold-off, picked up by the receiver process

  task automatic clear_command();
    m_cmd_busy = 1'b0;
    m_cmd      = CMD_NONE;
    m_argc     = 0;
    m_args[0]  = 8'd0;
    m_args[1]  = 8'd0;
    m_args[2]  = 8'd0;
  endtask

  task automatic reset_parser_model();
    m_enhanced  = 1'b0;
    m_bit_image = 1'b0;
    m_lock      = 1'b0;
    m_business  = 1'b0;
    m_fine      = 1'b0;
    m_x         = 0;
    clear_command();
  endtask

  function automatic logic [2:0] current_font();
    if (m_bit_image) return FONT_BIT_IMAGE;
    return (m_business ? FONT_BUSINESS : FONT_GRAPHIC) + (m_enhanced ? 3'd1 : 3'd0);
  endfunction

  task automatic queue_event(input logic [2:0] kind, input logic [7:0] c,
                             input logic [2:0] f, input int n);
    print_event_t ev;
    ev.kind    = kind;
    ev.code    = c;
    ev.font    = f;
    ev.count   = n[15:0];
    ev.x_after = m_x[15:0];
    ev.pitch   = m_fine ? PITCH_FINE : PITCH_NORMAL;
    pending_events.push_back(ev);
  endtask

  // Tab argument: leading whitespace, optional sign, digits; stops at a non-digit
  function automatic int tab_number();
    int   i;
    int   v;
    logic neg;
    i   = 0;
    v   = 0;
    neg = 1'b0;
    while (i < 3 && (m_args[i] == 8'd32 || (m_args[i] >= 8'd9 && m_args[i] <= 8'd13)))
      i++;
    if (i < 3 && (m_args[i] == "+" || m_args[i] == "-")) begin
      neg = (m_args[i] == "-");
      i++;
    end
    while (i < 3 && m_args[i] >= "0" && m_args[i] <= "9") begin
      v = v * 10 + int'(m_args[i] - 8'h30);
      i++;
    end
    return neg ? -v : v;
  endfunction

  // Advance the model by one accepted transaction and queue its event, if any
  task automatic advance_parser(input logic o, input logic [7:0] c, input logic [7:0] ch);
    int n;
    int col;
    int w;
    if (o == OP_CLEAR) begin
      // clears enhanced, bit image and the lock; command and pitch survive
      m_enhanced  = 1'b0;
      m_bit_image = 1'b0;
      m_lock      = 1'b0;
    end else begin
      if (!m_lock) m_business = (ch == CHANNEL_BUS);
      if (m_bit_image) begin
        if (c == BYTE_ENH_ON || c == BYTE_ENH_OFF) begin
          m_enhanced  = (c == BYTE_ENH_ON);
          m_bit_image = 1'b0;
          m_fine      = 1'b0;
        end else if (c == BYTE_REPEAT) begin
          m_bit_image = 1'b0;
          m_cmd_busy  = 1'b1;
          m_cmd       = CMD_REPEAT;
        end else begin
          queue_event(EV_BITMAP, c, FONT_BIT_IMAGE, 1);
        end
      end else if (m_cmd_busy) begin
        if (m_argc > 2) begin
          clear_command();
        end else begin
          m_args[m_argc] = c;
          m_argc++;
          if (m_argc >= 2) begin
            case (m_cmd)
              CMD_TAB: begin
                n   = tab_number();
                col = m_x / CHAR_W;
                clear_command();
                if (n > col) queue_event(EV_PAD, CODE_SPACE, FONT_GRAPHIC, n - col);
              end
              CMD_REPEAT: begin
                n = (m_args[0] != 8'd0) ? int'(m_args[0]) : 256;
                clear_command();
                queue_event(EV_REPEAT, c, FONT_BIT_IMAGE, n);
              end
              CMD_DOT: begin
                // first argument is ignored; needs all three
                if (m_argc == 3) begin
                  n   = int'({m_args[1], m_args[2]});
                  col = m_x / DOT_W;
                  clear_command();
                  if (n > col) queue_event(EV_PAD, CODE_SPACE, FONT_BIT_IMAGE, n - col);
                end
              end
              default: clear_command();
            endcase
          end
        end
      end else begin
        case (c)
          BYTE_ENH_ON:    m_enhanced = 1'b1;
          BYTE_ENH_OFF:   m_enhanced = 1'b0;
          BYTE_BIT_IMAGE: begin
            m_bit_image = 1'b1;
            m_fine      = 1'b1;
          end
          BYTE_LF: begin
            m_x = 0;
            queue_event(EV_LF, CODE_NONE, current_font(), 1);
          end
          BYTE_LOCK_BUS: begin
            m_lock     = 1'b1;
            m_business = 1'b1;
          end
          BYTE_LOCK_GR: begin
            m_lock     = 1'b1;
            m_business = 1'b0;
          end
          BYTE_TAB: begin
            m_cmd_busy = 1'b1;
            m_cmd      = CMD_TAB;
          end
          BYTE_DOT: begin
            m_cmd_busy = 1'b1;
            m_cmd      = CMD_DOT;
          end
          default: begin
            if ((c >= PRINT_LO && c <= PRINT_HI) || c >= PRINT_UPPER) begin
              w   = m_enhanced ? CHAR_W_WIDE : CHAR_W;
              m_x = (m_x > POS_MAX - w) ? POS_MAX : m_x + w;  // saturating advance
              queue_event(EV_CHAR, c, current_font(), 1);
            end
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one transaction per call. Entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic o, input logic [7:0] b, input logic [7:0] ch);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    data_byte  <= b;
    channel    <= ch;
    // accepted at the first rising edge with stall low
    @(posedge clk);
    while (item_stall) @(posedge clk);
    advance_parser(o, b, ch);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_channel();
    return ($urandom_range(0, 3) == 0) ? CHANNEL_BUS : 8'($urandom);
  endfunction

  task automatic send_data(input logic [7:0] b);
    send_item(OP_DATA, b, random_channel());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: drives event_stall at the falling edge. A long hold-off is
  // counted here; otherwise it waits the cycles the checker drew.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        event_stall <= 1'b1;
        hold_left--;
      end else if (rx_wait > 0) begin
        event_stall <= 1'b1;
        rx_wait--;
      end else begin
        event_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Checker: each accepted output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : event_checker
    print_event_t want;
    if (!rst && event_valid && !event_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d code %0h", event_kind, code));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind)
          report_mismatch($sformatf("event %0d kind %0d, want %0d",
                                    events_checked, event_kind, want.kind));
        if (code !== want.code)
          report_mismatch($sformatf("event %0d code %0h, want %0h",
                                    events_checked, code, want.code));
        if (font !== want.font)
          report_mismatch($sformatf("event %0d font %0d, want %0d",
                                    events_checked, font, want.font));
        if (count !== want.count)
          report_mismatch($sformatf("event %0d count %0d, want %0d",
                                    events_checked, count, want.count));
        if (x_after !== want.x_after)
          report_mismatch($sformatf("event %0d x_after %0d, want %0d",
                                    events_checked, x_after, want.x_after));
        if (line_pitch !== want.pitch)
          report_mismatch($sformatf("event %0d line_pitch %0d, want %0d",
                                    events_checked, line_pitch, want.pitch));
        if (want.kind <= EV_LF) kind_seen[want.kind]++;
      end
      events_checked++;
      rx_wait = no_gaps ? 0 : $urandom_range(0, 5);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Printable range edges, business channel, ignored and no-op bytes
  task automatic test_characters();
    send_item(OP_DATA, PRINT_LO, 8'h00);
    send_item(OP_DATA, PRINT_HI, 8'hff);
    send_item(OP_DATA, PRINT_UPPER, CHANNEL_BUS);
    send_item(OP_DATA, 8'hff, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00);
    send_item(OP_DATA, 8'h9f, 8'h00);
    send_item(OP_DATA, BYTE_NOP_A, 8'h00);
    send_item(OP_DATA, BYTE_NOP_B, 8'h00);
  endtask

  // Enhanced mode, set locks, and the clear operation
  task automatic test_modes();
    send_item(OP_DATA, BYTE_ENH_ON, 8'h00);
    send_item(OP_DATA, BYTE_LOCK_BUS, 8'h00);
    send_item(OP_DATA, "A", 8'h00);          // locked business, wide
    send_item(OP_CLEAR, 8'hff, 8'hff);
    send_item(OP_DATA, BYTE_LOCK_GR, CHANNEL_BUS);
    send_item(OP_DATA, BYTE_LF, CHANNEL_BUS); // graphic lock wins over channel
  endtask

  // Tab and dot address commands
  task automatic test_commands();
    send_item(OP_DATA, BYTE_TAB, 8'h00);
    send_item(OP_DATA, "2", 8'h00);
    send_item(OP_DATA, "0", 8'h00);
    send_item(OP_DATA, BYTE_TAB, 8'h00);      // negative tab: no event
    send_item(OP_DATA, "-", 8'h00);
    send_item(OP_DATA, "5", 8'h00);
    send_item(OP_DATA, BYTE_DOT, 8'h00);      // largest dot column
    send_item(OP_DATA, 8'h00, 8'h00);
    send_item(OP_DATA, 8'hff, 8'h00);
    send_item(OP_DATA, 8'hff, 8'h00);
  endtask

  // Bit image columns, repeat with zero count, exit through enhanced off
  task automatic test_bit_image();
    send_item(OP_DATA, BYTE_BIT_IMAGE, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00);
    send_item(OP_DATA, BYTE_REPEAT, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00);         // zero count means 256
    send_item(OP_DATA, 8'hff, 8'h00);
    send_item(OP_DATA, BYTE_BIT_IMAGE, 8'h00);
    send_item(OP_DATA, BYTE_ENH_OFF, 8'h00);
  endtask

  // Run the position into its ceiling, then commands against a full line
  task automatic test_position_saturation();
    no_gaps = 1'b1;
    send_data(BYTE_ENH_ON);
    repeat (460) send_data(8'($urandom_range(PRINT_LO, PRINT_HI)));
    send_data(BYTE_ENH_OFF);
    send_data(8'($urandom_range(PRINT_UPPER, 8'hff)));
    send_data(BYTE_DOT);
    send_data(8'($urandom));
    send_data(8'hff);
    send_data(8'hff);
    send_data(BYTE_TAB);                      // col far beyond 99: no event
    send_data("9");
    send_data("9");
    send_data(BYTE_LF);
    no_gaps = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering: the queue fills
  task automatic test_backpressure();
    no_gaps      = 1'b1;
    hold_request = 60;
    repeat (40) send_data(8'($urandom_range(PRINT_LO, PRINT_HI)));
    no_gaps = 1'b0;
  endtask

  function automatic logic [7:0] tab_arg_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd32;
      1:       return 8'($urandom_range(9, 13));
      2:       return "+";
      3:       return "-";
      4, 5, 6: return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed command and mode sequences with random content, plus noise
  task automatic test_random_stream();
    int pick;
    int n;
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 11) == 0) no_gaps = ~no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) send_data(8'($urandom_range(PRINT_LO, PRINT_HI)));
          else send_data(8'($urandom_range(PRINT_UPPER, 8'hff)));
        end
      end else if (pick < 35) begin
        if (m_bit_image) send_data(BYTE_ENH_OFF);
        send_data(BYTE_TAB);
        send_data(tab_arg_byte());
        send_data(tab_arg_byte());
      end else if (pick < 45) begin
        if (m_bit_image) send_data(BYTE_ENH_ON);
        send_data(BYTE_DOT);
        send_data(8'($urandom));
        send_data(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
        send_data(8'($urandom));
      end else if (pick < 60) begin
        if (!m_bit_image) send_data(BYTE_BIT_IMAGE);
        n = $urandom_range(0, 6);
        repeat (n) send_data(8'($urandom));
        case ($urandom_range(0, 2))
          0: begin
            if (m_bit_image) send_data(BYTE_REPEAT);
            send_data(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            send_data(8'($urandom));
          end
          1: send_data(BYTE_ENH_ON);
          default: send_data(BYTE_ENH_OFF);
        endcase
      end else if (pick < 68) begin
        send_data(BYTE_LF);
      end else if (pick < 76) begin
        case ($urandom_range(0, 5))
          0: send_data(BYTE_ENH_ON);
          1: send_data(BYTE_ENH_OFF);
          2: send_data(BYTE_LOCK_BUS);
          3: send_data(BYTE_LOCK_GR);
          4: send_data(BYTE_NOP_A);
          default: send_data(BYTE_NOP_B);
        endcase
      end else if (pick < 83) begin
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom));
      end else begin
        // noise, including broken command sequences
        n = $urandom_range(1, 4);
        repeat (n) send_item(($urandom_range(0, 4) == 0) ? OP_CLEAR : OP_DATA,
                             8'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    op           = OP_DATA;
    data_byte    = 8'd0;
    channel      = 8'd0;
    event_stall  = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    events_checked = 0;
    no_gaps      = 1'b0;
    rx_wait      = 0;
    hold_request = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    reset_parser_model();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_characters();
    test_modes();
    test_commands();
    test_bit_image();
    test_position_saturation();
    test_backpressure();
    test_random_stream();

    item_valid <= 1'b0;
    // drain, then wait for a stray late event
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d input transactions, %0d events checked", items_sent, events_checked);
    $display("  char %0d, column %0d, repeat %0d, pad %0d, line feed %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
